/* sv/c3g_pkg.sv */
package c3g_pkg;

	localparam int PIX_W     = 8;
	localparam int COEF_W    = 24;
	localparam int DIM_W     = 12;
	localparam int CFG_IDX_W = 3;
	localparam int TAPS      = 9;
	localparam int KROWS     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 3'd4;

	localparam logic [COEF_W-1:0] COEF_TOP_RST    = 24'h000000;
	localparam logic [COEF_W-1:0] COEF_MIDDLE_RST = 24'h000100;
	localparam logic [COEF_W-1:0] COEF_BOTTOM_RST = 24'h000000;
	localparam logic [DIM_W-1:0]  WIDTH_RST       = 12'd640;
	localparam logic [DIM_W-1:0]  HEIGHT_RST      = 12'd480;

	localparam int QDEPTH = 4;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t [TAPS-1:0] win;
		logic            zero;
		logic            last;
	} c3g_job_t;

	typedef struct packed {
		logic [COEF_W-1:0] bot;
		logic [COEF_W-1:0] mid;
		logic [COEF_W-1:0] top;
	} c3g_coef_t;

endpackage

/* sv/c3g_front.sv */
module c3g_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [c3g_pkg::PIX_W-1:0] pixel_in,
	input  logic                      flush,
	input  logic [c3g_pkg::DIM_W-1:0] image_width,
	input  logic [c3g_pkg::DIM_W-1:0] image_height,
	input  logic [c3g_pkg::QCNT_W-1:0] q_count,
	output logic                      push,
	output c3g_pkg::c3g_job_t         push_job
);
	import c3g_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int WW = (CW > DIM_W) ? CW : DIM_W;
	localparam int XW = WW + 2;
	localparam int RW = DIM_W + 1;
	localparam logic [XW-1:0] MAXW_X = XW'(MAX_WIDTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

	pix_t above_mem [MAX_WIDTH];
	pix_t two_mem [MAX_WIDTH];

	logic [AW-1:0]    col_q;
	logic [DIM_W-1:0] row_q;
	logic [XW-1:0]    pend_q;
	logic             clr_q;
	logic [AW-1:0]    clr_addr_q;
	pix_t [TAPS-1:0]  win_q;
	pix_t             above_rd_q;
	pix_t             two_rd_q;

	logic             v_s1, flush_s1, emit_s1;
	pix_t             px_s1;
	logic [XW-1:0]    c_s1, p_s1;
	logic [RW-1:0]    r_s1;

	logic             v_s2, flush_s2, emit_s2;
	logic [XW-1:0]    co_s2;
	logic [RW-1:0]    ro_s2;

	logic [XW-1:0] iw, w_x, col_x, c0, c1, lag, p0, cw, co;
	logic [RW-1:0] h_r, r1, r0, r2, ro;
	logic          wrap_c, wrap_n, emit_px, emit_fl, accept;
	logic [AW-1:0] col_n;
	logic [DIM_W-1:0] row_n;
	logic [XW-1:0] pend_n;
	logic [QCNT_W+1:0] credit;
	logic          mem_we, border, last;
	logic [AW-1:0] wr_addr;
	pix_t          wd_above, wd_two;

	always_comb begin
		iw  = XW'(image_width);
		w_x = (iw < XW'(3)) ? XW'(3) : ((iw > MAXW_X) ? MAXW_X : iw);
		h_r = (RW'(image_height) < RW'(3)) ? RW'(3) : RW'(image_height);

		col_x  = XW'(col_q);
		wrap_c = col_x >= w_x;
		c0     = wrap_c ? '0 : col_x;
		r1     = wrap_c ? RW'(row_q) + RW'(1) : RW'(row_q);
		r0     = (r1 >= h_r) ? '0 : r1;
		lag    = w_x + XW'(1);
		p0     = (pend_q > lag) ? lag : pend_q;

		emit_px = p0 == lag;
		emit_fl = p0 != '0;

		c1     = c0 + XW'(1);
		wrap_n = c1 >= w_x;
		r2     = wrap_n ? r0 + RW'(1) : r0;

		if (flush) begin
			col_n  = c0[AW-1:0];
			row_n  = r0[DIM_W-1:0];
			pend_n = emit_fl ? p0 - XW'(1) : p0;
		end else begin
			col_n  = wrap_n ? '0 : c1[AW-1:0];
			row_n  = (r2 >= h_r) ? '0 : r2[DIM_W-1:0];
			pend_n = emit_px ? p0 : p0 + XW'(1);
		end
	end

	assign credit   = (QCNT_W+2)'(q_count) + (QCNT_W+2)'(v_s1) + (QCNT_W+2)'(v_s2);
	assign in_ready = !clr_q && (credit < (QCNT_W+2)'(QDEPTH));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			pend_q     <= '0;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == LAST_ADDR) begin
					clr_q <= 1'b0;
				end
			end
			if (accept) begin
				col_q  <= col_n;
				row_q  <= row_n;
				pend_q <= pend_n;
			end
		end
	end

	// line buffers: clear after reset, then shift one row down per pixel
	assign mem_we   = clr_q || (v_s1 && !flush_s1);
	assign wr_addr  = clr_q ? clr_addr_q : c_s1[AW-1:0];
	assign wd_above = clr_q ? '0 : px_s1;
	assign wd_two   = clr_q ? '0 : above_rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			above_mem[wr_addr] <= wd_above;
		end
		above_rd_q <= above_mem[c0[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			two_mem[wr_addr] <= wd_two;
		end
		two_rd_q <= two_mem[c0[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flush_s1 <= flush;
			emit_s1  <= flush ? emit_fl : emit_px;
			px_s1    <= pixel_in;
			c_s1     <= c0;
			r_s1     <= r0;
			p_s1     <= p0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1 && !flush_s1) begin
			for (int r = 0; r < KROWS; r++) begin
				win_q[r*KROWS]     <= win_q[r*KROWS + 1];
				win_q[r*KROWS + 1] <= win_q[r*KROWS + 2];
			end
			win_q[2] <= two_rd_q;
			win_q[5] <= above_rd_q;
			win_q[8] <= px_s1;
		end
	end

	// step back from the newest position to the one owed
	always_comb begin
		cw = c_s1 + w_x;
		if (p_s1 <= c_s1) begin
			co = c_s1 - p_s1;
			ro = r_s1;
		end else if (p_s1 <= cw) begin
			co = cw - p_s1;
			ro = (r_s1 == '0) ? h_r - RW'(1) : r_s1 - RW'(1);
		end else begin
			co = w_x - XW'(1);
			ro = (r_s1 >= RW'(2)) ? r_s1 - RW'(2) : r_s1 + h_r - RW'(2);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			flush_s2 <= flush_s1;
			emit_s2  <= emit_s1;
			co_s2    <= co;
			ro_s2    <= ro;
		end
	end

	always_comb begin
		last   = (ro_s2 == h_r - RW'(1)) && (co_s2 == w_x - XW'(1));
		border = (ro_s2 == '0) || (ro_s2 == h_r - RW'(1)) ||
		         (co_s2 == '0) || (co_s2 == w_x - XW'(1));
	end

	assign push          = v_s2 && emit_s2;
	assign push_job.win  = win_q;
	assign push_job.zero = flush_s2 || border;
	assign push_job.last = last;

endmodule

/* sv/c3g_queue.sv */
module c3g_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  c3g_pkg::c3g_job_t          push_job,
	input  logic                       pop,
	output c3g_pkg::c3g_job_t          pop_job,
	output logic                       q_valid,
	output logic [c3g_pkg::QCNT_W-1:0] count
);
	import c3g_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	c3g_job_t          mem_q [QDEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	assign pop_job = mem_q[rd_q];
	assign q_valid = cnt_q != '0;
	assign count   = cnt_q;

endmodule

/* sv/c3g_back.sv */
module c3g_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  c3g_pkg::c3g_coef_t        coef,
	input  logic                      q_valid,
	input  c3g_pkg::c3g_job_t         pop_job,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [c3g_pkg::PIX_W-1:0] pixel_out,
	output logic                      frame_end
);
	import c3g_pkg::*;

	logic [KROWS-1:0][COEF_W-1:0] rows;
	pix_t [TAPS-1:0]  coef_b;
	pix_t [TAPS-1:0]  prod;
	pix_t [TAPS-1:0]  prod_s1;
	logic             v_s1, zero_s1, last_s1;
	logic             adv_out, adv_s1;
	pix_t             sum;

	assign rows = {coef.bot, coef.mid, coef.top};

	always_comb begin
		for (int r = 0; r < KROWS; r++) begin
			for (int c = 0; c < KROWS; c++) begin
				coef_b[r*KROWS + c] = rows[r][c*PIX_W +: PIX_W];
			end
		end
	end

	assign adv_out = !out_valid || out_ready;
	assign adv_s1  = !v_s1 || adv_out;
	assign pop     = q_valid && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= q_valid;
			end
			if (adv_out) begin
				out_valid <= v_s1;
			end
		end
	end

	// low byte of each product is all the wrapped sum needs
	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			prod[k] = PIX_W'(coef_b[k] * pop_job.win[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1 <= prod;
			zero_s1 <= pop_job.zero;
			last_s1 <= pop_job.last;
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < TAPS; k++) begin
			sum = sum + prod_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s1) begin
			pixel_out <= zero_s1 ? '0 : sum;
			frame_end <= last_s1;
		end
	end

endmodule

/* sv/conv3x3_gray_filter_core.sv */
// channel  | handshake              | word
// ---------+------------------------+----------------------------------
// input    | in_valid / in_ready    | pixel_in, flush
// output   | out_valid / out_ready  | pixel_out, frame_end
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One input word per cycle while in_ready is high; the line buffer read, then
// the window shift with the owed-position step, take two stages ahead of a
// four-entry queue. A result then passes the queue and the back end's product
// and output registers. After reset all MAX_WIDTH line buffer entries are
// cleared with in_ready low; configuration writes are taken throughout.
// An output stall drops in_ready when queued and in-flight words total four.
module conv3x3_gray_filter_core #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [c3g_pkg::PIX_W-1:0]     pixel_in,
	input  logic                          flush,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [c3g_pkg::PIX_W-1:0]     pixel_out,
	output logic                          frame_end,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [c3g_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [c3g_pkg::COEF_W-1:0]    cfg_data
);
	import c3g_pkg::*;

	c3g_coef_t         coef_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [QCNT_W-1:0] q_count;
	logic              push, pop, q_valid;
	c3g_job_t          push_job, pop_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.top <= COEF_TOP_RST;
			coef_q.mid <= COEF_MIDDLE_RST;
			coef_q.bot <= COEF_BOTTOM_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COEF_TOP: begin
					coef_q.top <= cfg_data;
				end
				REG_COEF_MIDDLE: begin
					coef_q.mid <= cfg_data;
				end
				REG_COEF_BOTTOM: begin
					coef_q.bot <= cfg_data;
				end
				REG_WIDTH: begin
					width_q <= cfg_data[DIM_W-1:0];
				end
				REG_HEIGHT: begin
					height_q <= cfg_data[DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	c3g_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_in     (pixel_in),
		.flush        (flush),
		.image_width  (width_q),
		.image_height (height_q),
		.q_count      (q_count),
		.push         (push),
		.push_job     (push_job)
	);

	c3g_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_valid  (q_valid),
		.count    (q_count)
	);

	c3g_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef_q),
		.q_valid   (q_valid),
		.pop_job   (pop_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.frame_end (frame_end)
	);

endmodule

/* sv/c3g_checker.sv */
module c3g_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [c3g_pkg::PIX_W-1:0] pixel_out,
	input logic                      frame_end
);

	// hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(frame_end))
		else $error("output word changed while stalled");

	// the last position of a frame is a corner, hence border
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> pixel_out == '0)
		else $error("frame end word carries a nonzero pixel");

	// line buffers are still being cleared just after reset
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready && !out_valid)
		else $error("input taken before line buffers cleared");

endmodule

bind conv3x3_gray_filter_core c3g_checker u_chk (.*);

/* tb/tb_conv3x3_gray_filter_core.sv */
module tb_conv3x3_gray_filter_core;
	import c3g_pkg::*;

	localparam int MAX_W      = 2048;
	localparam int SETTLE     = 16;
	localparam int RAND_WORDS = 1500;
	localparam int DIR_N      = 26;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_HEIGHT + 1'b1;

	typedef struct packed {
		pix_t pix;
		logic last;
	} filt_t;

	typedef struct packed {
		pix_t px;
		logic fl;
		logic typed;
		pix_t px_exp;
		logic last_exp;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	pix_t                 pixel_in;
	logic                 flush;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	pix_t                 pixel_out;
	logic                 frame_end;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	logic [COEF_W-1:0] k_row [KROWS];
	logic [DIM_W-1:0]  w_reg;
	logic [DIM_W-1:0]  h_reg;
	pix_t              ln_prev  [MAX_W];
	pix_t              ln_prev2 [MAX_W];
	pix_t              win      [TAPS];
	int unsigned       col_pos;
	int unsigned       row_pos;
	int unsigned       owed;

	filt_t filt_q [$];
	int    errors;
	int    words_in;
	bit    calm;

	// identity kernel, 3x3 frames: only the centre position is not border
	dir_row_t dir_rows [DIR_N] = '{
		'{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
		'{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h7F, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hA5, 1'b0, 1'b1, 8'h00, 1'b0},
		'{8'h01, 1'b0, 1'b1, 8'h00, 1'b0},
		'{8'hFE, 1'b0, 1'b1, 8'h00, 1'b0},
		'{8'h5A, 1'b0, 1'b1, 8'h00, 1'b0},
		'{8'hC3, 1'b0, 1'b1, 8'hA5, 1'b0},
		'{8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
		'{8'hFF, 1'b1, 1'b1, 8'h00, 1'b0},
		'{8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
		'{8'hFF, 1'b1, 1'b1, 8'h00, 1'b1},
		'{8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
		'{8'h3C, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h12, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hFF, 1'b0, 1'b1, 8'h00, 1'b0},
		'{8'h34, 1'b0, 1'b1, 8'h00, 1'b0},
		'{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
		'{8'h56, 1'b0, 1'b1, 8'h00, 1'b0},
		'{8'h78, 1'b0, 1'b1, 8'hFF, 1'b0},
		'{8'hE7, 1'b0, 1'b1, 8'h00, 1'b0},
		'{8'h9D, 1'b0, 1'b1, 8'h00, 1'b0}
	};

	conv3x3_gray_filter_core #(
		.MAX_WIDTH(MAX_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pixel_in (pixel_in),
		.flush    (flush),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_out(pixel_out),
		.frame_end(frame_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic void reset_filter();
		k_row[0] = COEF_TOP_RST;
		k_row[1] = COEF_MIDDLE_RST;
		k_row[2] = COEF_BOTTOM_RST;
		w_reg    = WIDTH_RST;
		h_reg    = HEIGHT_RST;
		for (int i = 0; i < MAX_W; i++) begin
			ln_prev[i]  = '0;
			ln_prev2[i] = '0;
		end
		for (int i = 0; i < TAPS; i++)
			win[i] = '0;
		col_pos = 0;
		row_pos = 0;
		owed    = 0;
	endfunction

	function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [COEF_W-1:0] data);
		case (idx)
			REG_COEF_TOP:    k_row[0] = data;
			REG_COEF_MIDDLE: k_row[1] = data;
			REG_COEF_BOTTOM: k_row[2] = data;
			REG_WIDTH:       w_reg = data[DIM_W-1:0];
			REG_HEIGHT:      h_reg = data[DIM_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic int unsigned eff_width();
		if (w_reg < 3)
			return 3;
		if (w_reg > MAX_W)
			return MAX_W;
		return 32'(w_reg);
	endfunction

	function automatic int unsigned eff_height();
		return (h_reg < 3) ? 3 : 32'(h_reg);
	endfunction

	function automatic void filter_step(input pix_t px, input logic fl,
			output bit hit, output filt_t res);
		int unsigned w;
		int unsigned h;
		int unsigned lag;
		int unsigned frame;
		int unsigned idx;
		int unsigned oidx;
		int unsigned ro;
		int unsigned co;
		pix_t        a;
		pix_t        b;
		int          acc;
		w   = eff_width();
		h   = eff_height();
		hit = 1'b0;
		res = '0;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		lag = w + 1;
		if (owed > lag)
			owed = lag;
		frame    = w * h;
		idx      = row_pos * w + col_pos;
		oidx     = (idx >= owed) ? idx - owed : idx + frame - owed;
		res.last = (oidx == frame - 1);
		if (fl) begin
			if (owed == 0)
				return;
			owed--;
			hit = 1'b1;
			return;
		end
		hit = (owed == lag);
		a = ln_prev2[col_pos];
		b = ln_prev[col_pos];
		ln_prev2[col_pos] = b;
		ln_prev[col_pos]  = px;
		for (int r = 0; r < KROWS; r++) begin
			win[3*r]   = win[3*r+1];
			win[3*r+1] = win[3*r+2];
		end
		win[2] = a;
		win[5] = b;
		win[8] = px;
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
		if (!hit) begin
			owed++;
			return;
		end
		ro = oidx / w;
		co = oidx % w;
		if (ro == 0 || ro == h - 1 || co == 0 || co == w - 1)
			return;
		acc = 0;
		for (int r = 0; r < KROWS; r++)
			for (int c = 0; c < 3; c++)
				acc += int'($signed(k_row[r][8*c +: 8])) * int'(win[3*r+c]);
		res.pix = acc[PIX_W-1:0];
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef();
		case ($urandom_range(9))
			0: return 24'h808080;
			1: return 24'h7F7F7F;
			2: return 24'hFFFFFF;
			3: return 24'h000000;
			4: return COEF_MIDDLE_RST;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_width(input bit big_ok);
		int unsigned sel;
		sel = $urandom_range(99);
		if (big_ok && sel < 6)
			return (sel < 2) ? 12'd2048 : (sel < 4) ? 12'hFFF : 12'd2049;
		if (sel < 12)
			return DIM_W'($urandom_range(2));
		if (sel < 25)
			return DIM_W'($urandom_range(64, 13));
		return DIM_W'($urandom_range(12, 3));
	endfunction

	function automatic logic [DIM_W-1:0] pick_height();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 8)
			return DIM_W'($urandom_range(2));
		if (sel < 11)
			return 12'hFFF;
		if (sel < 14)
			return DIM_W'($urandom_range(4095, 21));
		if (sel < 30)
			return DIM_W'($urandom_range(20, 9));
		return DIM_W'($urandom_range(8, 3));
	endfunction

	task automatic push_word(input pix_t px, input logic fl, input bit typed = 1'b0,
			input filt_t typed_res = '0);
		bit    hit;
		filt_t res;
		while (!calm && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= px;
		flush    <= fl;
		do @(posedge clk); while (!in_ready);
		filter_step(px, fl, hit, res);
		if (hit)
			filt_q.push_back(typed ? typed_res : res);
		words_in++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, data);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (filt_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= 16);

	always @(posedge clk) begin
		filt_t want;
		if (arst_n && out_valid && out_ready) begin
			if (filt_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: pixel_out %h frame_end %b", pixel_out, frame_end);
			end else begin
				want = filt_q.pop_front();
				if (pixel_out !== want.pix || frame_end !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: pixel_out exp %h got %h, frame_end exp %b got %b",
							want.pix, pixel_out, want.last, frame_end);
				end
			end
		end
	end

	initial begin
		int unsigned w;
		int unsigned h;
		int unsigned nfr;
		int unsigned npix;
		int unsigned nfl;
		int unsigned big_left;
		int          phase_no;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		pixel_in  = '0;
		flush     = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		errors    = 0;
		words_in  = 0;
		calm      = 1'b0;
		big_left  = 1;
		reset_filter();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_reg(REG_COEF_TOP, COEF_TOP_RST);
		write_reg(REG_COEF_MIDDLE, COEF_MIDDLE_RST);
		write_reg(REG_COEF_BOTTOM, COEF_BOTTOM_RST);
		write_reg(REG_WIDTH, 24'd3);
		write_reg(REG_HEIGHT, 24'd3);
		cfg_valid <= 1'b0;

		foreach (dir_rows[i])
			push_word(dir_rows[i].px, dir_rows[i].fl, dir_rows[i].typed,
				filt_t'{dir_rows[i].px_exp, dir_rows[i].last_exp});

		phase_no = 0;
		while (words_in < DIR_N + RAND_WORDS) begin
			settle();
			calm = 1'b0;
			if (phase_no == 0 || $urandom_range(1))
				write_reg(REG_COEF_TOP, pick_coef());
			if (phase_no == 0 || $urandom_range(1))
				write_reg(REG_COEF_MIDDLE, pick_coef());
			if (phase_no == 0 || $urandom_range(1))
				write_reg(REG_COEF_BOTTOM, pick_coef());
			if (phase_no == 0 || eff_width() > 64 || $urandom_range(1))
				write_reg(REG_WIDTH, {12'($urandom), pick_width(big_left > 0)});
			if (phase_no == 0 || $urandom_range(1))
				write_reg(REG_HEIGHT, {12'($urandom), pick_height()});
			if ($urandom_range(7) == 0)
				write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(2)), COEF_W'($urandom));
			cfg_valid <= 1'b0;
			phase_no++;
			w = eff_width();
			h = eff_height();

			if (w > 64) begin
				big_left--;
				calm = 1'b1;
				npix = w + 1 + $urandom_range(40, 1);
				repeat (npix) push_word(PIX_W'($urandom), 1'b0);
			end else begin
				calm = ($urandom_range(7) == 0);
				nfr  = (w * h > 200) ? 1 : $urandom_range(3, 1);
				repeat (nfr) begin
					npix = (h <= 20) ? w * h : $urandom_range(4 * w, w);
					if ($urandom_range(9) == 0)
						npix = $urandom_range(npix, 1);
					repeat (npix) begin
						if ($urandom_range(39) == 0)
							push_word(PIX_W'($urandom), 1'b1);
						push_word(PIX_W'($urandom), 1'b0);
					end
					case ($urandom_range(4))
						0, 1, 2: nfl = w + 1 + $urandom_range(2);
						3:       nfl = $urandom_range(w);
						default: nfl = 0;
					endcase
					repeat (nfl) push_word(PIX_W'($urandom), 1'b1);
				end
			end
		end

		settle();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
sv/c3g_pkg.sv
sv/c3g_front.sv
sv/c3g_queue.sv
sv/c3g_back.sv
sv/conv3x3_gray_filter_core.sv
sv/c3g_checker.sv
tb/tb_conv3x3_gray_filter_core.sv
